### hw/rtl/fdd_pkg.sv
// fdd_pkg: shared constants, payload types and helpers for the finite-difference core
// used by every module under hw/rtl; depends on nothing else
package fdd_pkg;

  // grid and number format
  localparam int unsigned MAX_GRID  = 4096;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned GRID_W    = 13;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned DIFF_W    = WORD_W + 1;

  // product lanes: six magnitude factors per lane, one limb multiply per stage
  localparam int unsigned FAC_W       = WORD_W;
  localparam int unsigned ACC_W       = 2 * FAC_W;
  localparam int unsigned NFAC        = 6;
  localparam int unsigned PROD_W      = FAC_W * NFAC;
  localparam int unsigned NLANE       = 4;
  localparam int unsigned LANE_DEN    = 3;
  localparam int unsigned LANE_STAGES = NFAC * (NFAC - 1) / 2;

  // merge and divide
  localparam int unsigned SUM_W     = PROD_W + 3;
  localparam int unsigned MAG_W     = PROD_W + 2;
  localparam int unsigned QUO_W     = WORD_W + 1;
  localparam int unsigned REM_W     = PROD_W + 1;
  localparam int unsigned SAT_SHIFT = QUO_W - FRAC_BITS;

  localparam logic [WORD_W-1:0] DER_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] DER_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [QUO_W:0]    MAG_LIMIT = (QUO_W+1)'(1) << (WORD_W - 1);

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = GRID_W;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BIASED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_POINTS  = 1'd1;

  typedef struct packed {
    logic [IDX_W-1:0]         node_index;
    logic signed [WORD_W-1:0] coord0;
    logic signed [WORD_W-1:0] coord1;
    logic signed [WORD_W-1:0] coord2;
    logic signed [WORD_W-1:0] coord3;
    logic signed [WORD_W-1:0] value0;
    logic signed [WORD_W-1:0] value1;
    logic signed [WORD_W-1:0] value2;
    logic signed [WORD_W-1:0] value3;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] derivative;
    logic                     degenerate;
  } out_t;

  typedef logic [FAC_W-1:0] fac_t;
  typedef fac_t [NFAC-1:0]  fac_vec_t;

  typedef struct packed {
    fac_vec_t fac;
    logic     neg;
  } lane_in_t;

  typedef struct packed {
    logic [PROD_W-1:0] mag;
    logic              neg;
  } lane_out_t;

  typedef struct packed {
    logic valid;
    logic deg;
  } ctl_t;

  typedef struct packed {
    logic valid;
    logic deg;
    logic sat;
    logic neg;
  } div_ctl_t;

  // magnitude of a coordinate or value difference, always below 2^32
  function automatic fac_t diff_mag(input logic [DIFF_W-1:0] d);
    logic [DIFF_W-1:0] m;
    m = d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
    return m[FAC_W-1:0];
  endfunction

endpackage

### hw/rtl/fdd_stencil.sv
// fdd_stencil: request capture, edge test and stencil differences for the lanes
// depends on fdd_pkg
module fdd_stencil (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  fdd_pkg::in_t                  in_i,
  input  logic                          right_biased_i,
  input  logic [fdd_pkg::GRID_W-1:0]    grid_points_i,
  output fdd_pkg::lane_in_t [fdd_pkg::NLANE-1:0] lane_o,
  output fdd_pkg::ctl_t                 ctl_o
);
  import fdd_pkg::*;

  in_t  item_q;
  logic rb_q;
  logic at_edge_d, at_edge_q;
  logic vld0_q;

  logic [DIFF_W-1:0] xs [4];
  logic [DIFF_W-1:0] vs [4];
  logic [DIFF_W-1:0] xc, x0, x1, x2, vc, v0, v1, v2;
  logic [DIFF_W-1:0] da, db, dc, dab, dac, dbc, fa, fb, fc, fn, fd;
  fac_t              one;

  lane_in_t [NLANE-1:0] lane_d, lane_q;
  logic                 deg_d;
  ctl_t                 ctl_q;

  // edge of the grid for the chosen bias
  always_comb begin
    if (right_biased_i) begin
      at_edge_d = (GRID_W'(in_i.node_index) + GRID_W'(1)) >= grid_points_i;
    end else begin
      at_edge_d = (in_i.node_index == '0);
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q    <= in_i;
      rb_q      <= right_biased_i;
      at_edge_q <= at_edge_d;
    end
  end

  // sign-extended slots
  assign xs[0] = {item_q.coord0[WORD_W-1], item_q.coord0};
  assign xs[1] = {item_q.coord1[WORD_W-1], item_q.coord1};
  assign xs[2] = {item_q.coord2[WORD_W-1], item_q.coord2};
  assign xs[3] = {item_q.coord3[WORD_W-1], item_q.coord3};
  assign vs[0] = {item_q.value0[WORD_W-1], item_q.value0};
  assign vs[1] = {item_q.value1[WORD_W-1], item_q.value1};
  assign vs[2] = {item_q.value2[WORD_W-1], item_q.value2};
  assign vs[3] = {item_q.value3[WORD_W-1], item_q.value3};

  // centre and outer slots
  always_comb begin
    if (rb_q) begin
      xc = xs[1]; x0 = xs[0]; x1 = xs[2]; x2 = xs[3];
      vc = vs[1]; v0 = vs[0]; v1 = vs[2]; v2 = vs[3];
    end else begin
      xc = xs[2]; x0 = xs[0]; x1 = xs[1]; x2 = xs[3];
      vc = vs[2]; v0 = vs[0]; v1 = vs[1]; v2 = vs[3];
    end
  end

  assign da  = x0 - xc;
  assign db  = x1 - xc;
  assign dc  = x2 - xc;
  assign dab = x0 - x1;
  assign dac = x0 - x2;
  assign dbc = x1 - x2;
  assign fa  = v0 - vc;
  assign fb  = v1 - vc;
  assign fc  = v2 - vc;
  assign fn  = vs[2] - vs[1];
  assign fd  = xs[2] - xs[1];
  assign one = FAC_W'(1);

  // factor sets: three numerator terms and the denominator, or one term and the denominator at a grid edge
  always_comb begin
    lane_d = '0;
    deg_d  = 1'b0;
    if (at_edge_q) begin
      lane_d[0].fac        = {one, one, one, one, one, diff_mag(fn)};
      lane_d[0].neg        = fn[DIFF_W-1];
      lane_d[LANE_DEN].fac = {one, one, one, one, one, diff_mag(fd)};
      lane_d[LANE_DEN].neg = fd[DIFF_W-1];
      deg_d                = (fd == '0);
    end else begin
      lane_d[0].fac = {diff_mag(db), diff_mag(db), diff_mag(dc), diff_mag(dc),
                       diff_mag(dbc), diff_mag(fa)};
      lane_d[0].neg = dbc[DIFF_W-1] ^ fa[DIFF_W-1];
      lane_d[1].fac = {diff_mag(da), diff_mag(da), diff_mag(dc), diff_mag(dc),
                       diff_mag(dac), diff_mag(fb)};
      lane_d[1].neg = ~(dac[DIFF_W-1] ^ fb[DIFF_W-1]);
      lane_d[2].fac = {diff_mag(da), diff_mag(da), diff_mag(db), diff_mag(db),
                       diff_mag(dab), diff_mag(fc)};
      lane_d[2].neg = dab[DIFF_W-1] ^ fc[DIFF_W-1];
      lane_d[LANE_DEN].fac = {diff_mag(da), diff_mag(db), diff_mag(dc),
                              diff_mag(dab), diff_mag(dac), diff_mag(dbc)};
      lane_d[LANE_DEN].neg = da[DIFF_W-1] ^ db[DIFF_W-1] ^ dc[DIFF_W-1] ^
                             dab[DIFF_W-1] ^ dac[DIFF_W-1] ^ dbc[DIFF_W-1];
      deg_d = (da == '0) || (db == '0) || (dc == '0) ||
              (dab == '0) || (dac == '0) || (dbc == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
      ctl_q  <= '0;
    end else if (en_i) begin
      vld0_q    <= valid_i;
      ctl_q.valid <= vld0_q;
      ctl_q.deg   <= deg_d;
    end
  end

  assign lane_o = lane_q;
  assign ctl_o  = ctl_q;

endmodule

### hw/rtl/fdd_lane.sv
// fdd_lane: one product lane, six 32-bit magnitudes multiplied limb by limb
// depends on fdd_pkg
module fdd_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  fdd_pkg::lane_in_t  lane_i,
  output fdd_pkg::lane_out_t lane_o
);
  import fdd_pkg::*;

  logic [PROD_W-1:0] prod_q  [LANE_STAGES];
  fac_t              carry_q [LANE_STAGES];
  fac_vec_t          fac_q   [LANE_STAGES];
  logic              neg_q   [LANE_STAGES];

  // factor k times the running product, one limb j per stage
  for (genvar k = 1; k < NFAC; k++) begin : g_fac
    for (genvar j = 0; j < k; j++) begin : g_limb
      localparam int unsigned S = k * (k - 1) / 2 + j;
      logic [PROD_W-1:0] p_in;
      logic [PROD_W-1:0] p_nxt;
      fac_t              c_in;
      fac_t              c_nxt;
      fac_vec_t          f_in;
      logic              n_in;
      logic [ACC_W-1:0]  acc;

      if (S == 0) begin : g_first
        assign p_in = PROD_W'(lane_i.fac[0]);
        assign c_in = '0;
        assign f_in = lane_i.fac;
        assign n_in = lane_i.neg;
      end else begin : g_next
        assign p_in = prod_q[S-1];
        assign c_in = carry_q[S-1];
        assign f_in = fac_q[S-1];
        assign n_in = neg_q[S-1];
      end

      assign acc = ACC_W'(p_in[j*FAC_W +: FAC_W]) * ACC_W'(f_in[k]) + ACC_W'(c_in);

      // running product with limb j replaced and the top limb filled on the last pass
      always_comb begin
        p_nxt                    = p_in;
        p_nxt[j*FAC_W +: FAC_W]  = acc[FAC_W-1:0];
        c_nxt                    = acc[ACC_W-1:FAC_W];
        if (j == k - 1) begin
          p_nxt[k*FAC_W +: FAC_W] = acc[ACC_W-1:FAC_W];
          c_nxt                   = '0;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q[S]  <= p_nxt;
          carry_q[S] <= c_nxt;
          fac_q[S]   <= f_in;
          neg_q[S]   <= n_in;
        end
      end
    end
  end

  assign lane_o.mag = prod_q[LANE_STAGES-1];
  assign lane_o.neg = neg_q[LANE_STAGES-1];

endmodule

### hw/rtl/fdd_merge.sv
// fdd_merge: sums the lane products, divides by the denominator lane, rounds and clamps
// depends on fdd_pkg
module fdd_merge (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  fdd_pkg::lane_out_t [fdd_pkg::NLANE-1:0] lane_i,
  input  fdd_pkg::ctl_t                           ctl_i,
  output fdd_pkg::out_t                           res_o,
  output logic                                    valid_o
);
  import fdd_pkg::*;

  function automatic logic [SUM_W-1:0] sval(input lane_out_t l);
    logic [SUM_W-1:0] m;
    m = SUM_W'(l.mag);
    return l.neg ? (~m + SUM_W'(1)) : m;
  endfunction

  // stage a: first two terms
  logic [SUM_W-1:0]  s01_q;
  lane_out_t         t2_q;
  lane_out_t         den_a_q;
  ctl_t              ctl_a_q;
  // stage b: full numerator
  logic [SUM_W-1:0]  n_q;
  lane_out_t         den_b_q;
  ctl_t              ctl_b_q;
  // stage c: magnitude and sign
  logic [MAG_W-1:0]  nmag_q;
  logic              neg_c_q;
  logic [PROD_W-1:0] dmag_c_q;
  ctl_t              ctl_c_q;
  // divider chain, element 0 loaded by the saturation stage
  logic [REM_W-1:0]  r_q    [QUO_W+1];
  logic [QUO_W-1:0]  low_q  [QUO_W+1];
  logic [QUO_W-1:0]  quo_q  [QUO_W+1];
  logic [PROD_W-1:0] dmag_q [QUO_W+1];
  div_ctl_t          dctl_q [QUO_W+1];
  // rounding and output
  logic              rnd_q;
  logic [QUO_W-1:0]  quo_r_q;
  div_ctl_t          dctl_r_q;
  logic [QUO_W:0]    q1;
  out_t              res_d, res_q;
  logic              valid_q;
  logic [MAG_W-1:0]  nshift;

  assign nshift = nmag_q >> SAT_SHIFT;

  // summing, magnitude and saturation stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s01_q    <= sval(lane_i[0]) + sval(lane_i[1]);
      t2_q     <= lane_i[2];
      den_a_q  <= lane_i[LANE_DEN];
      n_q      <= s01_q + sval(t2_q);
      den_b_q  <= den_a_q;
      nmag_q   <= MAG_W'(n_q[SUM_W-1] ? (~n_q + SUM_W'(1)) : n_q);
      neg_c_q  <= n_q[SUM_W-1] ^ den_b_q.neg;
      dmag_c_q <= den_b_q.mag;
      r_q[0]   <= REM_W'(nshift);
      low_q[0] <= {nmag_q[SAT_SHIFT-1:0], {FRAC_BITS{1'b0}}};
      quo_q[0] <= '0;
      dmag_q[0] <= dmag_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q   <= '0;
      ctl_b_q   <= '0;
      ctl_c_q   <= '0;
      dctl_q[0] <= '0;
    end else if (en_i) begin
      ctl_a_q         <= ctl_i;
      ctl_b_q         <= ctl_a_q;
      ctl_c_q         <= ctl_b_q;
      dctl_q[0].valid <= ctl_c_q.valid;
      dctl_q[0].deg   <= ctl_c_q.deg;
      dctl_q[0].sat   <= nshift >= MAG_W'(dmag_c_q);
      dctl_q[0].neg   <= neg_c_q;
    end
  end

  // one quotient bit per stage
  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    logic [REM_W-1:0] r2;
    logic             ge;

    assign r2 = {r_q[i][REM_W-2:0], low_q[i][QUO_W-1]};
    assign ge = r2 >= REM_W'(dmag_q[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i+1]    <= ge ? (r2 - REM_W'(dmag_q[i])) : r2;
        low_q[i+1]  <= {low_q[i][QUO_W-2:0], 1'b0};
        quo_q[i+1]  <= {quo_q[i][QUO_W-2:0], ge};
        dmag_q[i+1] <= dmag_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dctl_q[i+1] <= '0;
      end else if (en_i) begin
        dctl_q[i+1] <= dctl_q[i];
      end
    end
  end

  // round half away from zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q   <= {r_q[QUO_W], 1'b0} >= (REM_W+1)'(dmag_q[QUO_W]);
      quo_r_q <= quo_q[QUO_W];
      res_q   <= res_d;
    end
  end

  // signed clamp to the output word
  assign q1 = (QUO_W+1)'(quo_r_q) + (QUO_W+1)'(rnd_q);

  always_comb begin
    res_d.degenerate = dctl_r_q.deg;
    if (dctl_r_q.deg) begin
      res_d.derivative = '0;
    end else if (dctl_r_q.sat) begin
      res_d.derivative = dctl_r_q.neg ? DER_MIN : DER_MAX;
    end else if (dctl_r_q.neg) begin
      res_d.derivative = (q1 > MAG_LIMIT) ? DER_MIN : WORD_W'(~q1 + (QUO_W+1)'(1));
    end else begin
      res_d.derivative = (q1 >= MAG_LIMIT) ? DER_MAX : WORD_W'(q1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dctl_r_q <= '0;
      valid_q  <= 1'b0;
    end else if (en_i) begin
      dctl_r_q <= dctl_q[QUO_W];
      valid_q  <= dctl_r_q.valid;
    end
  end

  assign res_o   = res_q;
  assign valid_o = valid_q;

endmodule

### hw/rtl/nonuniform_fd_derivative_core.sv
// nonuniform_fd_derivative_core: top level, configuration registers, lanes and output skid
// depends on fdd_pkg, fdd_stencil, fdd_lane and fdd_merge
//
// Usage
//   Input channel in_valid_i / in_stall_o / in_i carries one node per request:
//   four slot coordinates, four slot values and the centre node index, Q16.16.
//   Output channel out_valid_o / out_stall_i / out_o returns one request per
//   input: the first derivative at the centre node and a degenerate flag.
//   A request is taken at a clock edge with valid high and stall low.
//   Configuration (right_biased, grid_points) is written through cfg_we_i,
//   cfg_idx_i and cfg_data_i while the core is idle.
//   Throughput: one request per cycle while out_stall_i does not freeze the
//   pipeline. Each product lane has 15 limb-multiply stages and the merge
//   unit has 33 one-bit restoring divide stages.
//   Reset: right_biased = 0, grid_points = 4096, pipeline and output empty.
//   When the receiver stalls, the held result stays in the output register and
//   the next one lands in a skid register; only then is in_stall_o raised and
//   the whole pipeline frozen until the output drains.
module nonuniform_fd_derivative_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fdd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fdd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fdd_pkg::in_t                      in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fdd_pkg::out_t                     out_o
);
  import fdd_pkg::*;

  logic              rb_q;
  logic [GRID_W-1:0] gp_q;
  logic              en;

  lane_in_t  [NLANE-1:0] lane_in;
  lane_out_t [NLANE-1:0] lane_out;
  ctl_t                  st_ctl;
  ctl_t                  ctl_dly_q [LANE_STAGES];
  out_t                  res;
  logic                  res_valid;
  logic                  take;

  out_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rb_q <= 1'b0;
      gp_q <= GRID_W'(MAX_GRID);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_RIGHT_BIASED: rb_q <= cfg_data_i[0];
        REG_GRID_POINTS:  gp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advances unless the skid register is occupied
  assign en = ~skid_valid_q;

  fdd_stencil u_stencil (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (in_valid_i),
    .in_i           (in_i),
    .right_biased_i (rb_q),
    .grid_points_i  (gp_q),
    .lane_o         (lane_in),
    .ctl_o          (st_ctl)
  );

  // numerator terms and denominator side by side
  for (genvar l = 0; l < NLANE; l++) begin : g_lane
    fdd_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .lane_i (lane_in[l]),
      .lane_o (lane_out[l])
    );
  end

  // control follows the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_dly_q <= '{default: '0};
    end else if (en) begin
      ctl_dly_q[0] <= st_ctl;
      for (int s = 1; s < LANE_STAGES; s++) begin
        ctl_dly_q[s] <= ctl_dly_q[s-1];
      end
    end
  end

  fdd_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .lane_i  (lane_out),
    .ctl_i   (ctl_dly_q[LANE_STAGES-1]),
    .res_o   (res),
    .valid_o (res_valid)
  );

  assign take = res_valid & en;

  // output register and skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= take;
      end
    end else if (take) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (take) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### hw/rtl/fdd_checker.sv
// fdd_checker: port-level assertions for the finite-difference core, bound to the top
// depends on fdd_pkg and nonuniform_fd_derivative_core
module fdd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input fdd_pkg::out_t                  out_o
);
  import fdd_pkg::*;

  // held request stays valid
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output request dropped while stalled");

  // held request keeps its payload
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_o))
    else $error("output payload changed while stalled");

  // degenerate stencil yields a zero derivative
  a_deg_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.degenerate |-> out_o.derivative == '0)
    else $error("degenerate result with non-zero derivative");

  // input stall only rises behind a stalled output
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a held output");

  // a full skid implies a pending output
  a_stall_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output");

endmodule

bind nonuniform_fd_derivative_core fdd_checker u_fdd_checker (.*);
